// ===== rtl/limit_order_fill_engine_core_macros.svh =====
// Assertion macros used by the checker of the fill engine.
`ifndef LIMIT_ORDER_FILL_ENGINE_CORE_MACROS_SVH
`define LIMIT_ORDER_FILL_ENGINE_CORE_MACROS_SVH

// Implication within the same cycle, quiet during reset.
`define LOFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, quiet during reset.
`define LOFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lofe_pkg.sv =====
// Types and codes shared by the fill engine modules.
package lofe_pkg;

  localparam logic [1:0] CMD_SUBMIT = 2'd0;
  localparam logic [1:0] CMD_TRADE  = 2'd1;
  localparam logic [1:0] CMD_QUOTE  = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [23:0] vol;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic        side;
    logic [31:0] price;
    logic [23:0] vol;
  } fill_req_t;

endpackage

// ===== rtl/lofe_cell.sv =====
// One cell of the pending-order chain: holds one order, loads or takes its neighbor's.
module lofe_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  lofe_pkg::entry_t load_data_i,
  input  logic            shift_i,
  input  lofe_pkg::entry_t nb_i,
  output lofe_pkg::entry_t entry_o
);

  lofe_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= load_data_i;
    end else if (shift_i) begin
      entry_q <= nb_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/lofe_acct.sv =====
// Position and cash account: pipelined fill accumulate and multi-cycle valuation.
module lofe_acct (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lofe_pkg::fill_req_t   fill_i,
  input  logic                  val_start_i,
  input  logic [31:0]           mark_i,
  output logic signed [47:0]    position_o,
  output logic signed [63:0]    cash_o,
  output logic signed [63:0]    value_o,
  output logic                  val_done_o
);

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [47:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] S48_MIN = 48'h8000_0000_0000;

  logic        s1_valid_q;
  logic        s1_side_q;
  logic [23:0] s1_vol_q;
  logic [55:0] s1_amt_q;
  logic [47:0] pos_q, pos_d;
  logic [63:0] cash_q, cash_d;
  logic [48:0] pos_sum;
  logic [64:0] cash_sum;

  logic [2:0]  vstep_q;
  logic        vneg_q;
  logic [47:0] vabs_q;
  logic [31:0] vmark_q;
  logic [63:0] plo_q;
  logic [47:0] phi_q;
  logic [63:0] value_q;
  logic        done_q;
  logic [79:0] prod;
  logic [65:0] vsum;
  logic [63:0] value_d;

  // Stage one: product of volume and price.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= fill_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= fill_i.side;
    s1_vol_q  <= fill_i.vol;
    s1_amt_q  <= 56'(fill_i.vol * fill_i.price);
  end

  // Stage two: saturating update of position and cash.
  always_comb begin
    pos_d  = pos_q;
    cash_d = cash_q;
    if (s1_side_q == lofe_pkg::SIDE_BUY) begin
      pos_sum  = {pos_q[47], pos_q} + {25'd0, s1_vol_q};
      cash_sum = {cash_q[63], cash_q} - {9'd0, s1_amt_q};
    end else begin
      pos_sum  = {pos_q[47], pos_q} - {25'd0, s1_vol_q};
      cash_sum = {cash_q[63], cash_q} + {9'd0, s1_amt_q};
    end
    if (s1_valid_q) begin
      if (pos_sum[48] != pos_sum[47]) begin
        pos_d = pos_sum[48] ? S48_MIN : S48_MAX;
      end else begin
        pos_d = pos_sum[47:0];
      end
      if (cash_sum[64] != cash_sum[63]) begin
        cash_d = cash_sum[64] ? S64_MIN : S64_MAX;
      end else begin
        cash_d = cash_sum[63:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      cash_q <= '0;
    end else begin
      pos_q  <= pos_d;
      cash_q <= cash_d;
    end
  end

  // Valuation: the 48 by 32 product is built from two halves on one multiplier slot each.
  always_comb begin
    prod = {phi_q, 32'd0} + {16'd0, plo_q};
    if (vneg_q) begin
      vsum = {{2{cash_q[63]}}, cash_q} - {2'd0, prod[63:0]};
    end else begin
      vsum = {{2{cash_q[63]}}, cash_q} + {2'd0, prod[63:0]};
    end
    if (|prod[79:64]) begin
      value_d = vneg_q ? S64_MIN : S64_MAX;
    end else if ((vsum[65:63] != 3'b000) && (vsum[65:63] != 3'b111)) begin
      value_d = vsum[65] ? S64_MIN : S64_MAX;
    end else begin
      value_d = vsum[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vstep_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q  <= vstep_q[2];
      vstep_q <= {vstep_q[1:0], val_start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_start_i) begin
      vneg_q  <= pos_q[47];
      vabs_q  <= pos_q[47] ? (~pos_q + 48'd1) : pos_q;
      vmark_q <= mark_i;
    end
    if (vstep_q[0]) begin
      plo_q <= vabs_q[31:0] * vmark_q;
    end
    if (vstep_q[1]) begin
      phi_q <= 48'(vabs_q[47:32] * vmark_q);
    end
    if (vstep_q[2]) begin
      value_q <= value_d;
    end
  end

  assign position_o = pos_q;
  assign cash_o     = cash_q;
  assign value_o    = value_q;
  assign val_done_o = done_q;

endmodule

// ===== rtl/limit_order_fill_engine_core.sv =====
// Limit-order fill engine: a chain of order cells scanned through one fill unit.
// One beat in, one beat out, and the next input beat is taken only after the result
// of the previous one is registered. A submit, or a tick with nothing pending, passes
// through ST_DRAIN to ST_OUT; a valuation query waits in ST_VAL for the account's
// valuation. A trade or quote tick shifts the order chain past the fill unit once per
// pending order. When some orders stay but do not fill the whole chain, it then
// rotates the survivors back to the front. Unfilled orders keep their arrival order.
module limit_order_fill_engine_core #(
  parameter int PENDING_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // command[1:0], order_is_market[2], order_side[3], order_price[35:4],
  // order_volume[59:36], trade_price[91:60], bid_price[123:92],
  // ask_price[155:124], mark_price[187:156], zero fill above
  input  logic [191:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status[0], fills[7:1], pending_count[14:8], position_now[62:15],
  // cash_now[126:63], portfolio_value[190:127], zero fill above
  output logic [191:0] m_axis_tdata_o
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_ROT   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_VAL   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [1:0]  in_cmd;
  logic        in_mkt;
  logic        in_side;
  logic [31:0] in_price;
  logic [23:0] in_vol;
  logic [31:0] in_mark;

  assign in_cmd   = s_axis_tdata_i[1:0];
  assign in_mkt   = s_axis_tdata_i[2];
  assign in_side  = s_axis_tdata_i[3];
  assign in_price = s_axis_tdata_i[35:4];
  assign in_vol   = s_axis_tdata_i[59:36];
  assign in_mark  = s_axis_tdata_i[187:156];

  logic [2:0]    state_q, state_d;
  logic [1:0]    cmd_q;
  logic [31:0]   trade_q, bid_q, ask_q;
  logic [CW-1:0] total_q, keep_q, idx_q, fills_q;
  logic          status_q, drain_q;
  logic          m_valid_q;
  logic [191:0]  m_data_q;

  logic                accept;
  logic                do_append;
  logic                full;
  lofe_pkg::entry_t    head;
  lofe_pkg::entry_t    new_entry;
  lofe_pkg::entry_t    ent [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] shift_en, load_en;
  logic                hit, scanning, last_scan, rot_all, hit_shift;
  logic [CW-1:0]       keep_next;
  logic [31:0]         lim;
  lofe_pkg::fill_req_t fill_req;

  logic signed [47:0] position;
  logic signed [63:0] cash;
  logic signed [63:0] value;
  logic               val_done;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (32'(total_q) >= 32'(PENDING_DEPTH));
  assign do_append       = accept && (in_cmd == lofe_pkg::CMD_SUBMIT) && !in_mkt && !full;
  assign new_entry       = '{side: in_side, price: in_price, vol: in_vol};
  assign head            = ent[0];

  always_comb begin
    if (cmd_q == lofe_pkg::CMD_TRADE) begin
      hit = (head.side == lofe_pkg::SIDE_BUY) ? (trade_q <= head.price)
                                              : (trade_q >= head.price);
    end else begin
      hit = (head.side == lofe_pkg::SIDE_BUY) ? (head.price >= ask_q)
                                              : (head.price <= bid_q);
    end
  end

  assign scanning  = (state_q == ST_SCAN);
  assign last_scan = scanning && (32'(idx_q) + 32'd1 == 32'(total_q));
  assign keep_next = keep_q + CW'(!hit);
  // A kept order rotates the whole chain; a filled order leaves, and the block of
  // kept orders at the top of the chain holds still.
  assign rot_all   = (scanning && !hit) || (state_q == ST_ROT);
  assign hit_shift = scanning && hit;
  assign lim       = 32'(PENDING_DEPTH - 1) - 32'(keep_q);

  for (genvar j = 0; j < PENDING_DEPTH; j++) begin : g_cell
    assign shift_en[j] = rot_all || (hit_shift && (32'(j) < lim));
    assign load_en[j]  = do_append && (32'(total_q) == 32'(j));
    lofe_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (load_en[j]),
      .load_data_i (new_entry),
      .shift_i     (shift_en[j]),
      .nb_i        ((j == PENDING_DEPTH - 1) ? head : ent[(j + 1) % PENDING_DEPTH]),
      .entry_o     (ent[j])
    );
  end

  always_comb begin
    fill_req = '{valid: 1'b0, side: in_side, price: in_price, vol: in_vol};
    if (accept && (in_cmd == lofe_pkg::CMD_SUBMIT) && in_mkt) begin
      fill_req.valid = 1'b1;
    end else if (hit_shift) begin
      fill_req = '{valid: 1'b1, side: head.side, price: head.price, vol: head.vol};
    end
  end

  lofe_acct u_acct (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fill_i      (fill_req),
    .val_start_i (accept && (in_cmd == lofe_pkg::CMD_QUERY)),
    .mark_i      (in_mark),
    .position_o  (position),
    .cash_o      (cash),
    .value_o     (value),
    .val_done_o  (val_done)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == lofe_pkg::CMD_QUERY) begin
            state_d = ST_VAL;
          end else if ((in_cmd == lofe_pkg::CMD_SUBMIT) || (total_q == '0)) begin
            state_d = ST_DRAIN;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_scan) begin
          if ((keep_next == '0) || (32'(keep_next) == 32'(PENDING_DEPTH))) begin
            state_d = ST_DRAIN;
          end else begin
            state_d = ST_ROT;
          end
        end
      end
      ST_ROT: begin
        if (32'(idx_q) + 32'(keep_q) + 32'd1 == 32'(PENDING_DEPTH)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_q) begin
          state_d = ST_OUT;
        end
      end
      ST_VAL: begin
        if (val_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      total_q   <= '0;
      keep_q    <= '0;
      idx_q     <= '0;
      fills_q   <= '0;
      status_q  <= 1'b0;
      drain_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= (state_q == ST_DRAIN) && !drain_q;
      if (accept) begin
        idx_q    <= '0;
        keep_q   <= '0;
        status_q <= (in_cmd == lofe_pkg::CMD_SUBMIT) && !in_mkt && full;
        fills_q  <= CW'((in_cmd == lofe_pkg::CMD_SUBMIT) && in_mkt);
        if (do_append) begin
          total_q <= total_q + CW'(1);
        end
      end else if (scanning) begin
        keep_q <= keep_next;
        if (hit) begin
          fills_q <= fills_q + CW'(1);
        end
        if (last_scan) begin
          total_q <= keep_next;
          idx_q   <= '0;
        end else begin
          idx_q <= idx_q + CW'(1);
        end
      end else if (state_q == ST_ROT) begin
        idx_q <= idx_q + CW'(1);
      end
      if (state_q == ST_OUT) begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_q <= 1'b1;
        end
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  logic [31:0] fills32, total32;
  logic [6:0]  fills_out, pend_out;
  logic [63:0] value_out;

  assign fills32   = 32'(fills_q);
  assign total32   = 32'(total_q);
  assign fills_out = (fills32 > 32'd127) ? 7'd127 : fills32[6:0];
  assign pend_out  = (total32 > 32'd127) ? 7'd127 : total32[6:0];
  assign value_out = (cmd_q == lofe_pkg::CMD_QUERY) ? value : 64'd0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_cmd;
      trade_q <= s_axis_tdata_i[91:60];
      bid_q   <= s_axis_tdata_i[123:92];
      ask_q   <= s_axis_tdata_i[155:124];
    end
    if ((state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i)) begin
      m_data_q <= {1'b0, value_out, cash, position, pend_out, fills_out, status_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== rtl/lofe_checker.sv =====
// Port-level checker for the fill engine, bound to the top level.
`include "limit_order_fill_engine_core_macros.svh"

module lofe_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [191:0] m_axis_tdata_o
);

  logic s_beat;
  logic m_stall;
  logic drop_beat;
  logic drop_clean;

  assign s_beat     = s_axis_tvalid_i && s_axis_tready_o;
  assign m_stall    = m_axis_tvalid_o && !m_axis_tready_i;
  assign drop_beat  = m_axis_tvalid_o && m_axis_tdata_o[0];
  assign drop_clean = (m_axis_tdata_o[7:1] == 7'd0) && (m_axis_tdata_o[190:127] == 64'd0);

  // The engine works on one item at a time.
  `LOFE_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, s_beat, !s_axis_tready_o, "ready after beat")
  // A dropped order fills nothing and carries no valuation.
  `LOFE_ASSERT_NOW(a_drop_clean, clk_i, rst_ni, drop_beat, drop_clean, "drop with fills or value")
  `LOFE_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, m_stall, m_axis_tvalid_o, "result withdrawn")
  `LOFE_ASSERT_NEXT(a_data_holds, clk_i, rst_ni, m_stall, $stable(m_axis_tdata_o), "result changed")

endmodule

bind limit_order_fill_engine_core lofe_checker u_lofe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
